FILE: sv/crcpd_pkg.sv
// ----------------------------------------------------------------------------
// crcpd_pkg
// Shared types, codes and CRC helper for the CRC packet response checker.
// ----------------------------------------------------------------------------
package crcpd_pkg;

    localparam logic [7:0]  MARK_HI    = 8'hFF;
    localparam logic [7:0]  MARK_LO    = 8'hFE;
    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [15:0] CRC_POLY   = 16'h1021;
    localparam logic [7:0]  HEAD_BYTES = 8'd7;
    localparam logic [7:0]  CRC_BYTES  = 8'd2;
    localparam logic [7:0]  META_BYTES = 8'd9;

    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_LEN_HI  = 3'd1,
        PH_LEN_LO  = 3'd2,
        PH_HEAD    = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_CRC_HI  = 3'd5,
        PH_CRC_LO  = 3'd6,
        PH_DONE    = 3'd7
    } phase_t;

    typedef enum logic [2:0] {
        VD_OK        = 3'd0,
        VD_NO_HEADER = 3'd1,
        VD_BAD_LEN   = 3'd2,
        VD_CRC       = 3'd3,
        VD_UNEXP_CMD = 3'd4,
        VD_NACK      = 3'd5,
        VD_TRUNC     = 3'd6
    } verdict_t;

    typedef enum logic {
        KIND_PAYLOAD = 1'b0,
        KIND_VERDICT = 1'b1
    } out_kind_t;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       buffer_start;
        logic       buffer_end;
        logic [7:0] expected_command;
    } in_item_t;

    typedef struct packed {
        out_kind_t  out_kind;
        logic [7:0] payload_byte;
        logic [7:0] command_code;
        logic [7:0] sub_code;
        logic [7:0] response_code;
        logic [7:0] payload_count;
        verdict_t   verdict;
    } result_t;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] data);
        logic [15:0] c;
        c = crc ^ {data, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

    localparam logic [15:0] HEADER_CRC = crc16_byte(crc16_byte(CRC_INIT, MARK_HI), MARK_LO);

endpackage

FILE: sv/crcpd_in_reg.sv
// ----------------------------------------------------------------------------
// crcpd_in_reg
// Input register: captures one byte transaction and holds it until the
// deframer advances.
// ----------------------------------------------------------------------------
module crcpd_in_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  crcpd_pkg::in_item_t s_item,
    input  logic              advance,
    output logic              in_valid,
    output crcpd_pkg::in_item_t in_item
);
    import crcpd_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    assign s_tready   = !valid_reg || advance;
    assign valid_next = s_tready ? s_tvalid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            item_reg <= s_item;
        end
    end

    assign in_valid = valid_reg;
    assign in_item  = item_reg;

endmodule

FILE: sv/crcpd_deframer.sv
// ----------------------------------------------------------------------------
// crcpd_deframer
// Header hunt, length check, field capture, CRC-16/CCITT-FALSE and verdict
// logic for one byte per cycle whenever fire is high.
// ----------------------------------------------------------------------------
module crcpd_deframer #(
    parameter int BUFFER_BYTES = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [7:0]          cfg_wr_data,
    input  logic                fire,
    input  crcpd_pkg::in_item_t in_item,
    output logic                res_valid,
    output crcpd_pkg::result_t  res
);
    import crcpd_pkg::*;

    localparam logic [7:0]  HUNT_LAST = 8'(BUFFER_BYTES - 2);
    localparam logic [15:0] BUF_LEN   = 16'(BUFFER_BYTES);
    localparam logic [9:0]  BUF_SUM   = 10'(BUFFER_BYTES);

    logic [7:0]  ack_code_reg;
    phase_t      phase_reg, phase_next;
    logic [7:0]  buffer_position_reg, buffer_position_next;
    logic        saw_first_marker_reg, saw_first_marker_next;
    logic [15:0] packet_length_reg, packet_length_next;
    logic [7:0]  packet_position_reg, packet_position_next;
    logic [15:0] running_crc_reg, running_crc_next;
    logic [7:0]  received_crc_high_reg, received_crc_high_next;
    logic [7:0]  held_command_reg, held_command_next;
    logic [7:0]  held_sub_reg, held_sub_next;
    logic [7:0]  held_response_reg, held_response_next;
    logic [7:0]  held_expected_reg, held_expected_next;

    phase_t      cur_phase;
    logic [7:0]  p;
    logic        cur_saw;
    logic [15:0] cur_len;
    logic [7:0]  cur_pos;
    logic [15:0] cur_crc;
    logic [7:0]  cur_crc_high;
    logic [7:0]  cur_cmd;
    logic [7:0]  cur_sub;
    logic [7:0]  cur_resp;
    logic [7:0]  b;
    logic [15:0] crc_step;
    logic [15:0] len_full;
    logic [9:0]  end_sum;
    logic        has_verdict;
    verdict_t    vd;
    logic        is_payload;
    logic [7:0]  count;

    always_comb
    begin
        b            = in_item.rx_byte;
        cur_phase    = in_item.buffer_start ? PH_HUNT : phase_reg;
        p            = in_item.buffer_start ? 8'd0 : buffer_position_reg;
        cur_saw      = in_item.buffer_start ? 1'b0 : saw_first_marker_reg;
        cur_len      = in_item.buffer_start ? 16'd0 : packet_length_reg;
        cur_pos      = in_item.buffer_start ? 8'd0 : packet_position_reg;
        cur_crc      = in_item.buffer_start ? CRC_INIT : running_crc_reg;
        cur_crc_high = in_item.buffer_start ? 8'd0 : received_crc_high_reg;
        cur_cmd      = in_item.buffer_start ? 8'd0 : held_command_reg;
        cur_sub      = in_item.buffer_start ? 8'd0 : held_sub_reg;
        cur_resp     = in_item.buffer_start ? 8'd0 : held_response_reg;
        held_expected_next = in_item.buffer_start ? in_item.expected_command
                                                  : held_expected_reg;

        crc_step = crc16_byte(cur_crc, b);
        len_full = {cur_len[15:8], b};
        end_sum  = {2'b00, p} - 10'd3 + {2'b00, len_full[7:0]};

        phase_next             = cur_phase;
        saw_first_marker_next  = cur_saw;
        packet_length_next     = cur_len;
        packet_position_next   = cur_pos;
        running_crc_next       = cur_crc;
        received_crc_high_next = cur_crc_high;
        held_command_next      = cur_cmd;
        held_sub_next          = cur_sub;
        held_response_next     = cur_resp;
        has_verdict            = 1'b0;
        vd                     = VD_OK;
        is_payload             = 1'b0;

        unique case (cur_phase)
            PH_HUNT:
            begin
                if (cur_saw && b == MARK_LO && p <= HUNT_LAST)
                begin
                    running_crc_next     = HEADER_CRC;
                    packet_position_next = 8'd2;
                    phase_next           = PH_LEN_HI;
                end
                else
                begin
                    saw_first_marker_next = (b == MARK_HI);
                    if (p >= HUNT_LAST)
                    begin
                        has_verdict = 1'b1;
                        vd          = VD_NO_HEADER;
                        phase_next  = PH_DONE;
                    end
                end
            end
            PH_LEN_HI:
            begin
                running_crc_next     = crc_step;
                packet_length_next   = {b, 8'h00};
                packet_position_next = 8'd3;
                phase_next           = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                running_crc_next     = crc_step;
                packet_length_next   = len_full;
                packet_position_next = 8'd4;
                if (len_full < 16'(META_BYTES) || len_full > BUF_LEN)
                begin
                    has_verdict = 1'b1;
                    vd          = VD_BAD_LEN;
                    phase_next  = PH_DONE;
                end
                else if (end_sum > BUF_SUM)
                begin
                    has_verdict = 1'b1;
                    vd          = VD_TRUNC;
                    phase_next  = PH_DONE;
                end
                else
                begin
                    phase_next = PH_HEAD;
                end
            end
            PH_HEAD:
            begin
                running_crc_next = crc_step;
                priority if (cur_pos == 8'd4)
                begin
                    held_command_next = b;
                end
                else if (cur_pos == 8'd5)
                begin
                    held_sub_next = b;
                end
                else
                begin
                    held_response_next = b;
                end
                packet_position_next = cur_pos + 8'd1;
                if (cur_pos + 8'd1 >= HEAD_BYTES)
                begin
                    phase_next = (cur_len > 16'(META_BYTES)) ? PH_PAYLOAD : PH_CRC_HI;
                end
            end
            PH_PAYLOAD:
            begin
                running_crc_next     = crc_step;
                is_payload           = 1'b1;
                packet_position_next = cur_pos + 8'd1;
                if ({8'h00, cur_pos + 8'd1} >= cur_len - 16'(CRC_BYTES))
                begin
                    phase_next = PH_CRC_HI;
                end
            end
            PH_CRC_HI:
            begin
                received_crc_high_next = b;
                packet_position_next   = cur_pos + 8'd1;
                phase_next             = PH_CRC_LO;
            end
            PH_CRC_LO:
            begin
                packet_position_next = cur_pos + 8'd1;
                has_verdict          = 1'b1;
                priority if ({cur_crc_high, b} != cur_crc)
                begin
                    vd = VD_CRC;
                end
                else if (cur_cmd != held_expected_next)
                begin
                    vd = VD_UNEXP_CMD;
                end
                else if (cur_resp != ack_code_reg)
                begin
                    vd = VD_NACK;
                end
                else
                begin
                    vd = VD_OK;
                end
                phase_next = PH_DONE;
            end
            PH_DONE:
            begin
            end
            default:
            begin
            end
        endcase

        buffer_position_next = (p < 8'd255) ? p + 8'd1 : p;

        if (!has_verdict && in_item.buffer_end && phase_next != PH_DONE)
        begin
            has_verdict = 1'b1;
            vd          = (phase_next == PH_HUNT) ? VD_NO_HEADER : VD_TRUNC;
            phase_next  = PH_DONE;
        end

        if (packet_length_next >= 16'(META_BYTES) && packet_length_next <= BUF_LEN)
        begin
            count = packet_length_next[7:0] - META_BYTES;
        end
        else
        begin
            count = 8'd0;
        end

        res_valid         = has_verdict || is_payload;
        res.out_kind      = has_verdict ? KIND_VERDICT : KIND_PAYLOAD;
        res.payload_byte  = has_verdict ? 8'd0 : b;
        res.command_code  = held_command_next;
        res.sub_code      = held_sub_next;
        res.response_code = held_response_next;
        res.payload_count = count;
        res.verdict       = has_verdict ? vd : VD_OK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ack_code_reg <= 8'd0;
        end
        else if (cfg_wr_en)
        begin
            ack_code_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg             <= PH_HUNT;
            buffer_position_reg   <= 8'd0;
            saw_first_marker_reg  <= 1'b0;
            packet_length_reg     <= 16'd0;
            packet_position_reg   <= 8'd0;
            running_crc_reg       <= CRC_INIT;
            received_crc_high_reg <= 8'd0;
            held_command_reg      <= 8'd0;
            held_sub_reg          <= 8'd0;
            held_response_reg     <= 8'd0;
            held_expected_reg     <= 8'd0;
        end
        else if (fire)
        begin
            phase_reg             <= phase_next;
            buffer_position_reg   <= buffer_position_next;
            saw_first_marker_reg  <= saw_first_marker_next;
            packet_length_reg     <= packet_length_next;
            packet_position_reg   <= packet_position_next;
            running_crc_reg       <= running_crc_next;
            received_crc_high_reg <= received_crc_high_next;
            held_command_reg      <= held_command_next;
            held_sub_reg          <= held_sub_next;
            held_response_reg     <= held_response_next;
            held_expected_reg     <= held_expected_next;
        end
    end

endmodule

FILE: sv/crcpd_out_reg.sv
// ----------------------------------------------------------------------------
// crcpd_out_reg
// Result register: holds one result transaction until the sink takes it.
// ----------------------------------------------------------------------------
module crcpd_out_reg (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               fire,
    input  logic               res_valid,
    input  crcpd_pkg::result_t res,
    output logic               advance,
    output logic               m_tvalid,
    input  logic               m_tready,
    output crcpd_pkg::result_t m_res
);
    import crcpd_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign advance    = !valid_reg || m_tready;
    assign valid_next = advance ? (fire && res_valid) : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && res_valid)
        begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_res    = res_reg;

endmodule

FILE: sv/crc_packet_response_checker_core.sv
// ----------------------------------------------------------------------------
// crc_packet_response_checker_core
// Path: an accepted byte is held in the input register, its result in the result register.
// Throughput: one byte per cycle while the sink does not stall; the bytewise CRC
// update and phase logic sit between the input register and the result register.
// Reset: asynchronous, active low; hunt restarts, CRC preset, ack_code cleared.
// ----------------------------------------------------------------------------
module crc_packet_response_checker_core #(
    parameter int BUFFER_BYTES = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,  // ack_code
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,      // rx_byte[7:0], expected_command[15:8]
    input  logic        s_tuser,      // buffer_start
    input  logic        s_tlast,      // buffer_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,      // payload_byte, command_code, sub_code,
                                      // response_code, payload_count, verdict[42:40]
    output logic        m_tuser       // out_kind
);
    import crcpd_pkg::*;

    in_item_t s_item;
    in_item_t in_item;
    logic     in_valid;
    logic     advance;
    logic     fire;
    logic     res_valid;
    result_t  res;
    result_t  m_res;

    assign s_item.rx_byte          = s_tdata[7:0];
    assign s_item.expected_command = s_tdata[15:8];
    assign s_item.buffer_start     = s_tuser;
    assign s_item.buffer_end       = s_tlast;

    assign fire = in_valid && advance;

    crcpd_in_reg u_in_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_item   (s_item),
        .advance  (advance),
        .in_valid (in_valid),
        .in_item  (in_item)
    );

    crcpd_deframer #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_deframer (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .fire        (fire),
        .in_item     (in_item),
        .res_valid   (res_valid),
        .res         (res)
    );

    crcpd_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .res_valid (res_valid),
        .res       (res),
        .advance   (advance),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_res     (m_res)
    );

    assign m_tdata = {5'd0, m_res.verdict, m_res.payload_count, m_res.response_code,
                      m_res.sub_code, m_res.command_code, m_res.payload_byte};
    assign m_tuser = m_res.out_kind;

endmodule
